// ===== hdl/coo_pkg.sv =====
`timescale 1ns / 1ps
package coo_pkg;
   localparam int ENTRIES     = 64;
   localparam int INDEX_WIDTH = 16;
   localparam int ADDR_W      = $clog2(ENTRIES);
   localparam int CNT_W       = $clog2(ENTRIES + 1);
   localparam int FIELD_W     = 16;
   localparam int VALUE_W     = 64;
   localparam int KEY_W       = 2 * INDEX_WIDTH;
   localparam int ENTRY_W     = KEY_W + VALUE_W;
   localparam int REQ_DATA_W  = 2 * FIELD_W + VALUE_W;
   localparam int RSP_DATA_W  = 2 * FIELD_W + VALUE_W;

   typedef struct packed {
      logic                load;
      logic                shift_start;
      logic                shift_step;
      logic                shift_done;
      logic                clear;
   } cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0]    count;
      logic                full;
      logic                pos_found;
   } status_type;
endpackage

// ===== hdl/coo_datapath.sv =====
`timescale 1ns / 1ps
module coo_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  coo_pkg::cmd_type              cmd,
   output coo_pkg::status_type           status,
   input  logic [coo_pkg::KEY_W-1:0]     in_key,
   input  logic [coo_pkg::VALUE_W-1:0]   in_value,
   input  logic [coo_pkg::ADDR_W-1:0]    rd_addr,
   output logic [coo_pkg::ENTRY_W-1:0]   rd_data,
   output logic                          overflow
);
   logic [coo_pkg::ENTRY_W-1:0] mem [coo_pkg::ENTRIES];
   logic [coo_pkg::ENTRY_W-1:0] rd_ff;
   logic [coo_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [coo_pkg::CNT_W-1:0]   pos_ff, pos_in;
   logic [coo_pkg::ENTRY_W-1:0] cur_ff;
   logic [coo_pkg::KEY_W-1:0]   key_ff;
   logic [coo_pkg::VALUE_W-1:0] val_ff;
   logic                        ovf_ff, ovf_in;
   logic [coo_pkg::ADDR_W-1:0]  raddr;
   logic                        we;
   logic [coo_pkg::ADDR_W-1:0]  waddr;
   logic [coo_pkg::ENTRY_W-1:0] wdata;
   logic                        full;

   assign full = (count_ff == coo_pkg::CNT_W'(coo_pkg::ENTRIES));

   // shift walks down from count-1; cur_ff holds mem[pos-1]
   always_comb begin
      raddr = rd_addr;
      if (cmd.load || cmd.shift_start)
         raddr = coo_pkg::ADDR_W'(count_ff - 1'b1);
      else if (cmd.shift_step)
         raddr = coo_pkg::ADDR_W'(pos_ff - 2'd2);
   end

   always_comb begin
      we = 1'b0;
      waddr = coo_pkg::ADDR_W'(pos_ff);
      wdata = {key_ff, val_ff};
      if (cmd.shift_step) begin
         we = 1'b1;
         wdata = cur_ff;
      end else if (cmd.shift_done) begin
         we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rd_ff <= mem[raddr];
      if (we) mem[waddr] <= wdata;
      if (cmd.load) begin
         key_ff <= in_key;
         val_ff <= in_value;
      end
   end
   assign cur_ff = rd_ff;

   always_comb begin
      pos_in = pos_ff;
      count_in = count_ff;
      ovf_in = ovf_ff;
      if (cmd.load) begin
         pos_in = count_ff;
         if (full) ovf_in = 1'b1;
      end
      if (cmd.shift_step) pos_in = pos_ff - 1'b1;
      if (cmd.shift_done) count_in = count_ff + 1'b1;
      if (cmd.clear) begin
         count_in = '0;
         pos_in = '0;
         ovf_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff <= 1'b0;
         pos_ff <= '0;
      end else begin
         count_ff <= count_in;
         ovf_ff <= ovf_in;
         pos_ff <= pos_in;
      end
   end

   // new entry goes after cur if key >= cur key (ties keep arrival order)
   assign status.pos_found = (pos_ff == '0) ||
                             (key_ff >= cur_ff[coo_pkg::ENTRY_W-1 -: coo_pkg::KEY_W]);
   assign status.count = count_ff;
   assign status.full = full;
   assign rd_data = rd_ff;
   assign overflow = ovf_ff;

   always_ff @(posedge clock) begin
      if (!reset) begin
         assert (count_ff <= coo_pkg::CNT_W'(coo_pkg::ENTRIES))
            else $error("count beyond capacity");
         assert (pos_ff <= count_ff) else $error("insert position beyond count");
      end
   end
   property p_grow;
      @(posedge clock) disable iff (reset) cmd.shift_done |=> count_ff != '0;
   endproperty
   a_grow: assert property (p_grow) else $error("count did not grow");
endmodule

// ===== hdl/coo_control.sv =====
`timescale 1ns / 1ps
module coo_control (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic                          req_tlast,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic                          rsp_tlast,
   output coo_pkg::cmd_type              cmd,
   input  coo_pkg::status_type           status,
   output logic [coo_pkg::ADDR_W-1:0]    rd_addr,
   output logic                          out_load
);
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;
   localparam logic [2:0] S_SHIFT = 3'd2;
   localparam logic [2:0] S_EMITR = 3'd3;
   localparam logic [2:0] S_EMITW = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   logic [2:0]                 state_ff, state_in;
   logic                       last_ff, last_in;
   logic                       drop_ff, drop_in;
   logic [coo_pkg::CNT_W-1:0]  idx_ff, idx_in;
   logic                       vld_ff, vld_in;
   logic                       tl_ff, tl_in;
   logic                       accept;

   assign req_tready = (state_ff == S_IDLE);
   assign accept = req_tvalid && req_tready;
   assign rd_addr = coo_pkg::ADDR_W'(idx_ff);

   always_comb begin
      state_in = state_ff;
      last_in = last_ff;
      drop_in = drop_ff;
      idx_in = idx_ff;
      vld_in = vld_ff;
      tl_in = tl_ff;
      cmd = '0;
      out_load = 1'b0;
      if (vld_ff && rsp_tready) vld_in = 1'b0;
      unique case (state_ff)
         S_IDLE: if (accept) begin
            cmd.load = 1'b1;
            last_in = req_tlast;
            drop_in = status.full;
            state_in = S_READ;
         end
         S_READ: begin
            if (drop_ff) begin
               idx_in = '0;
               state_in = last_ff ? S_EMITR : S_IDLE;
            end else begin
               cmd.shift_start = 1'b1;
               state_in = S_SHIFT;
            end
         end
         S_SHIFT: begin
            if (status.pos_found) begin
               cmd.shift_done = 1'b1;
               idx_in = '0;
               state_in = last_ff ? S_EMITR : S_IDLE;
            end else begin
               cmd.shift_step = 1'b1;
            end
         end
         S_EMITR: state_in = S_EMITW;
         S_EMITW: if (!vld_ff || rsp_tready) begin
            out_load = 1'b1;
            vld_in = 1'b1;
            tl_in = (idx_ff + 1'b1 == status.count);
            idx_in = idx_ff + 1'b1;
            state_in = (idx_ff + 1'b1 == status.count) ? S_OUT : S_EMITR;
         end
         S_OUT: if (!vld_in) begin
            cmd.clear = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         last_ff <= 1'b0;
         drop_ff <= 1'b0;
         idx_ff <= '0;
         vld_ff <= 1'b0;
         tl_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_ff <= last_in;
         drop_ff <= drop_in;
         idx_ff <= idx_in;
         vld_ff <= vld_in;
         tl_ff <= tl_in;
      end
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tlast = tl_ff;

   property p_no_accept_busy;
      @(posedge clock) disable iff (reset) (state_ff != S_IDLE) |-> !req_tready;
   endproperty
   a_no_accept_busy: assert property (p_no_accept_busy) else $error("ready while busy");
   property p_emit_bound;
      @(posedge clock) disable iff (reset)
         (state_ff == S_EMITW) |-> idx_ff < status.count;
   endproperty
   a_emit_bound: assert property (p_emit_bound) else $error("emit past count");
endmodule

// ===== hdl/coo_entry_row_major_sorter.sv =====
`timescale 1ns / 1ps
// COO entry row-major sorter.
// req_* stream: one word per matrix entry (row, column, 64-bit value);
// req_tlast marks the final entry of a set. Entries are kept in a 64-deep
// store ordered by row, then column; equal keys keep arrival order.
// Insertion shifts larger entries up one slot per cycle through the store's
// single write port. Entries past 64 are dropped and flagged.
// After the last entry, the set leaves on rsp_* in sorted order, one word
// at a time through a registered memory read, then the output register;
// rsp_tlast marks the final word, rsp_tuser flags a set that lost entries.
// req_tready is low while inserting or emitting. A stalled rsp_tready holds
// the output word and pauses the emit walk; nothing is lost.
// Reset (synchronous, active high) empties the store at once; no clearing
// pass is needed.
module coo_entry_row_major_sorter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [coo_pkg::REQ_DATA_W-1:0]    req_tdata,  // row_index, col_index, value_bits
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [coo_pkg::RSP_DATA_W-1:0]    rsp_tdata,  // sorted_row, sorted_col, sorted_value
   output logic                              rsp_tlast,
   output logic                              rsp_tuser   // overflowed
);
   coo_pkg::cmd_type                  cmd;
   coo_pkg::status_type               status;
   logic [coo_pkg::ADDR_W-1:0]        rd_addr;
   logic [coo_pkg::ENTRY_W-1:0]       rd_data;
   logic                              overflow;
   logic                              out_load;
   logic [coo_pkg::KEY_W-1:0]         in_key;
   logic [coo_pkg::RSP_DATA_W-1:0]    data_ff;
   logic                              user_ff;
   logic [coo_pkg::INDEX_WIDTH-1:0]   orow, ocol;

   assign in_key = {req_tdata[coo_pkg::INDEX_WIDTH-1:0],
                    req_tdata[coo_pkg::FIELD_W +: coo_pkg::INDEX_WIDTH]};

   coo_datapath u_dp (
      .clock, .reset, .cmd, .status, .in_key,
      .in_value(req_tdata[2*coo_pkg::FIELD_W +: coo_pkg::VALUE_W]),
      .rd_addr, .rd_data, .overflow
   );

   coo_control u_ctl (
      .clock, .reset, .req_tvalid, .req_tready, .req_tlast,
      .rsp_tvalid, .rsp_tready, .rsp_tlast, .cmd, .status, .rd_addr, .out_load
   );

   assign orow = rd_data[coo_pkg::ENTRY_W-1 -: coo_pkg::INDEX_WIDTH];
   assign ocol = rd_data[coo_pkg::VALUE_W +: coo_pkg::INDEX_WIDTH];

   always_ff @(posedge clock) begin
      if (out_load) begin
         data_ff <= {rd_data[coo_pkg::VALUE_W-1:0],
                     coo_pkg::FIELD_W'(ocol), coo_pkg::FIELD_W'(orow)};
         user_ff <= overflow;
      end
   end

   assign rsp_tdata = data_ff;
   assign rsp_tuser = user_ff;
endmodule

// ===== dv/coo_entry_row_major_sorter_tb.sv =====
`timescale 1ns / 1ps
module coo_entry_row_major_sorter_tb;

   typedef struct {
      logic [coo_pkg::FIELD_W-1:0] row;
      logic [coo_pkg::FIELD_W-1:0] col;
      logic [coo_pkg::VALUE_W-1:0] value;
      logic                        last;
      logic                        ovf;
   } entry_type;

   class sorted_board;
      entry_type held[$];
      entry_type pending[$];
      bit        dropped;
      int        errors;

      function void note_entry(logic [coo_pkg::INDEX_WIDTH-1:0] r,
                               logic [coo_pkg::INDEX_WIDTH-1:0] c,
                               logic [coo_pkg::VALUE_W-1:0] v, logic last);
         entry_type e;
         int        pos;
         e.row = r;
         e.col = c;
         e.value = v;
         e.last = 0;
         e.ovf = 0;
         if (held.size() >= coo_pkg::ENTRIES) begin
            dropped = 1;
         end else begin
            pos = held.size();
            while (pos > 0 && (held[pos-1].row > r ||
                   (held[pos-1].row == r && held[pos-1].col > c)))
               pos--;
            held.insert(pos, e);
         end
         if (last) begin
            foreach (held[k]) begin
               e = held[k];
               e.last = (k == held.size() - 1);
               e.ovf = dropped;
               pending.insert(pending.size(), e);
            end
            held.delete();
            dropped = 0;
         end
      endfunction

      function void check_word(logic [coo_pkg::RSP_DATA_W-1:0] d, logic last, logic ovf);
         entry_type e;
         if (pending.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected word %h", d);
            return;
         end
         e = pending.pop_front();
         if (d !== {e.value, e.col, e.row} || last !== e.last || ovf !== e.ovf) begin
            errors++;
            if (errors <= 10)
               $display("mismatch exp %h/%h/%h l%b o%b got %h l%b o%b",
                        e.row, e.col, e.value, e.last, e.ovf, d, last, ovf);
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0, req_tlast = 0, rsp_tready = 0;
   logic [coo_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic req_tready, rsp_tvalid, rsp_tlast, rsp_tuser;
   logic [coo_pkg::RSP_DATA_W-1:0] rsp_tdata;
   sorted_board board = new();

   coo_entry_row_major_sorter dut (.*);

   always #2 clock = ~clock;

   initial begin
      #4000000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // valid stays high across back-to-back words; dropped only for a gap
   task automatic send_entry(logic [15:0] r, logic [15:0] c, logic [63:0] v, logic last);
      int gap;
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {v, c, r};
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      board.note_entry(r, c, v, last);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_word(rsp_tdata, rsp_tlast, rsp_tuser);
   end

   initial begin
      int stall;
      @(posedge clock);
      while (1) begin
         stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
         rsp_tready <= (stall == 0);
         repeat (stall == 0 ? 1 : stall) @(posedge clock);
         rsp_tready <= 1;
         @(posedge clock);
      end
   end

   initial begin
      int n, sent, lim;
      board.errors = 0;
      board.dropped = 0;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: extremes, ties, single entry
      send_entry(16'hFFFF, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF, 0);
      send_entry(16'h0000, 16'h0000, 64'h0, 0);
      send_entry(16'h0005, 16'h0003, 64'h1, 0);
      send_entry(16'h0005, 16'h0003, 64'h2, 0);
      send_entry(16'h0005, 16'h0001, 64'h3, 0);
      send_entry(16'h0004, 16'hFFFF, 64'h4, 1);
      send_entry(16'h1234, 16'h5678, rand64(), 1);
      // overflow: 66 entries, last two dropped
      for (int i = 0; i < 66; i++)
         send_entry(16'($urandom_range(0, 7)), 16'($urandom_range(0, 7)), rand64(),
                    i == 65);
      sent = 0;
      while (sent < 130) begin
         n = $urandom_range(1, 12);
         lim = $urandom_range(0, 2) == 0 ? 65535 : 15;
         for (int i = 0; i < n; i++)
            send_entry(16'($urandom_range(0, lim)), 16'($urandom_range(0, lim)), rand64(),
                       i == n - 1);
         sent += n;
      end
      req_tvalid <= 0;
      wait (board.pending.size() == 0);
      repeat (200) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
